// ----- rtl/core/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg
// shared types, codes and constants of the register machine execute core
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int NUM_REGS       = 5;
    localparam int REG_IDX_W      = 3;
    localparam int DATA_W         = 64;
    localparam int PC_W           = 16;
    localparam int PLEN_W         = 17;
    localparam int OP_W           = 5;
    localparam int STATUS_W       = 2;
    localparam int COST_W         = 7;
    localparam int MEM_DEPTH_DEF  = 1024;
    localparam int PROG_DEPTH_DEF = 65536;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [COST_W-1:0] COST_IO  = 7'd100;
    localparam logic [COST_W-1:0] COST_MEM = 7'd10;
    localparam logic [COST_W-1:0] COST_ALU = 7'd1;

    localparam logic [PLEN_W-1:0] PLEN_RESET = 17'd65536;

    typedef enum logic [OP_W-1:0] {
        OP_GET     = 5'd0,
        OP_PUT     = 5'd1,
        OP_LOAD    = 5'd2,
        OP_STORE   = 5'd3,
        OP_COPY    = 5'd4,
        OP_ADD     = 5'd5,
        OP_SUB     = 5'd6,
        OP_SHR     = 5'd7,
        OP_SHL     = 5'd8,
        OP_INC     = 5'd9,
        OP_DEC     = 5'd10,
        OP_ZERO    = 5'd11,
        OP_JUMP    = 5'd12,
        OP_JZERO   = 5'd13,
        OP_JODD    = 5'd14,
        OP_HALT    = 5'd15,
        OP_COMMENT = 5'd16
    } op_t;

    typedef enum logic [1:0] {
        CC_NONE,
        CC_ALU,
        CC_MEM,
        CC_IO
    } cost_class_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_PC_RANGE  = 2'd1,
        STAT_MEM_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_EXEC,
        S_MEMRD
    } state_t;

    // decoded instruction as it travels through the queue
    typedef struct packed {
        op_t                   opcode;
        logic [REG_IDX_W-1:0]  reg_index;
        logic                  mem_op;
        logic                  mem_read;
        cost_class_t           cost_class;
        logic [PC_W-1:0]       jump_target;
        logic [DATA_W-1:0]     get_value;
    } instr_t;

    function automatic logic [COST_W-1:0] cost_amount(input cost_class_t cc);
        logic [COST_W-1:0] amt;
        unique case (cc)
            CC_NONE: amt = '0;
            CC_ALU:  amt = COST_ALU;
            CC_MEM:  amt = COST_MEM;
            CC_IO:   amt = COST_IO;
            default: amt = '0;
        endcase
        return amt;
    endfunction

endpackage

// ----- rtl/core/rme_front.sv -----
// ----------------------------------------------------------------------------
// rme_front
// request intake and instruction classification ahead of the queue
// ----------------------------------------------------------------------------
module rme_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rme_pkg::OP_W-1:0]      s_opcode,
    input  logic [rme_pkg::REG_IDX_W-1:0] s_reg_index,
    input  logic [rme_pkg::PC_W-1:0]      s_jump_target,
    input  logic [rme_pkg::DATA_W-1:0]    s_get_value,
    input  logic                          queue_full,
    input  logic                          clearing,
    output logic                          push_valid,
    output rme_pkg::instr_t               push_data
);
    import rme_pkg::*;

    op_t op;

    assign s_ready    = !queue_full && !clearing;
    assign push_valid = s_valid && s_ready;

    // undefined codes behave as a comment
    always_comb begin
        if (s_opcode <= OP_W'(OP_COMMENT)) begin
            op = op_t'(s_opcode);
        end else begin
            op = OP_COMMENT;
        end
    end

    always_comb begin
        push_data.opcode      = op;
        push_data.reg_index   = (s_reg_index > REG_IDX_W'(NUM_REGS - 1))
                                ? REG_IDX_W'(NUM_REGS - 1) : s_reg_index;
        push_data.jump_target = s_jump_target;
        push_data.get_value   = s_get_value;
        push_data.mem_op      = 1'b0;
        push_data.mem_read    = 1'b0;
        unique case (op)
            OP_GET, OP_PUT: begin
                push_data.cost_class = CC_IO;
            end
            OP_LOAD, OP_ADD, OP_SUB: begin
                push_data.cost_class = CC_MEM;
                push_data.mem_op     = 1'b1;
                push_data.mem_read   = 1'b1;
            end
            OP_STORE: begin
                push_data.cost_class = CC_MEM;
                push_data.mem_op     = 1'b1;
            end
            OP_COPY, OP_SHR, OP_SHL, OP_INC, OP_DEC, OP_ZERO,
            OP_JUMP, OP_JZERO, OP_JODD: begin
                push_data.cost_class = CC_ALU;
            end
            OP_HALT, OP_COMMENT: begin
                push_data.cost_class = CC_NONE;
            end
            default: begin
                push_data.cost_class = CC_NONE;
            end
        endcase
    end

endmodule

// ----- rtl/core/rme_queue.sv -----
// ----------------------------------------------------------------------------
// rme_queue
// short first-in first-out queue of decoded instructions
// ----------------------------------------------------------------------------
module rme_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  rme_pkg::instr_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rme_pkg::instr_t head_data
);
    import rme_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    instr_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_valid && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_valid && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // a push never lands on a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push_valid)
        else $error("push into full instruction queue");

endmodule

// ----- rtl/core/rme_back.sv -----
// ----------------------------------------------------------------------------
// rme_back
// execution of queued instructions: register file, data memory, pc, cost
// ----------------------------------------------------------------------------
module rme_back #(
    parameter int MEM_DEPTH  = rme_pkg::MEM_DEPTH_DEF,
    parameter int PROG_DEPTH = rme_pkg::PROG_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rme_pkg::PLEN_W-1:0]    cfg_wr_data,
    input  logic                          head_valid,
    input  rme_pkg::instr_t               head_data,
    output logic                          pop,
    output logic                          clearing,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rme_pkg::PC_W-1:0]      m_next_pc,
    output logic                          m_put_valid,
    output logic [rme_pkg::DATA_W-1:0]    m_put_value,
    output logic                          m_halted,
    output logic [rme_pkg::STATUS_W-1:0]  m_status,
    output logic [rme_pkg::DATA_W-1:0]    m_total_cost
);
    import rme_pkg::*;

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] mem_rdata_reg;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [DATA_W-1:0] regs_reg [NUM_REGS];
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [DATA_W-1:0] cost_reg, cost_next;
    logic              halt_reg, halt_next;
    logic [PLEN_W-1:0] plen_reg;

    logic              m_valid_reg, m_valid_next;
    logic [PC_W-1:0]   m_next_pc_reg;
    logic              m_put_valid_reg;
    logic [DATA_W-1:0] m_put_value_reg;
    logic              m_halted_reg;
    status_t           m_status_reg;

    logic              out_free;
    logic [DATA_W-1:0] reg_sel;
    logic              addr_ok;
    logic [PLEN_W-1:0] next_seq;
    logic [PLEN_W-1:0] next_pc17;
    logic [PLEN_W-1:0] limit;
    logic              exec_now;
    logic              complete;
    logic              res_put;
    status_t           res_status;
    logic              reg_we;
    logic [REG_IDX_W-1:0] reg_widx;
    logic [DATA_W-1:0] reg_wdata;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata;

    assign out_free = !m_valid_reg || m_ready;
    assign reg_sel  = regs_reg[head_data.reg_index];
    assign addr_ok  = (regs_reg[0] < DATA_W'(MEM_DEPTH));
    assign next_seq = {1'b0, pc_reg} + 1'b1;
    assign limit    = (plen_reg < PLEN_W'(PROG_DEPTH)) ? plen_reg : PLEN_W'(PROG_DEPTH);
    assign clearing = (state_reg == S_CLEAR);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        exec_now      = 1'b0;
        complete      = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = regs_reg[0][AW-1:0];
        mem_wdata     = reg_sel;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MEM_DEPTH - 1)) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (head_valid && out_free) begin
                    if (halt_reg || !head_data.mem_op || !addr_ok) begin
                        exec_now = 1'b1;
                        complete = 1'b1;
                    end else if (head_data.mem_read) begin
                        mem_re     = 1'b1;
                        state_next = S_MEMRD;
                    end else begin
                        exec_now = 1'b1;
                        complete = 1'b1;
                        mem_we   = 1'b1;
                    end
                end
            end
            S_MEMRD: begin
                exec_now   = 1'b1;
                complete   = 1'b1;
                state_next = S_EXEC;
            end
            default: begin
                state_next = S_EXEC;
            end
        endcase
    end

    assign pop = complete;

    // instruction effect
    always_comb begin
        pc_next    = pc_reg;
        cost_next  = cost_reg;
        halt_next  = halt_reg;
        reg_we     = 1'b0;
        reg_widx   = head_data.reg_index;
        reg_wdata  = reg_sel;
        res_put    = 1'b0;
        res_status = STAT_OK;
        next_pc17  = next_seq;
        if (exec_now && !halt_reg) begin
            cost_next = cost_reg + DATA_W'(cost_amount(head_data.cost_class));
            if (head_data.mem_op && !addr_ok) begin
                halt_next  = 1'b1;
                res_status = STAT_MEM_RANGE;
            end else if (head_data.opcode == OP_HALT) begin
                halt_next = 1'b1;
            end else begin
                unique case (head_data.opcode)
                    OP_GET: begin
                        reg_we    = 1'b1;
                        reg_wdata = head_data.get_value;
                    end
                    OP_PUT: res_put = 1'b1;
                    OP_LOAD: begin
                        reg_we    = 1'b1;
                        reg_wdata = mem_rdata_reg;
                    end
                    OP_COPY: begin
                        reg_we   = 1'b1;
                        reg_widx = '0;
                    end
                    OP_ADD: begin
                        reg_we    = 1'b1;
                        reg_wdata = reg_sel + mem_rdata_reg;
                    end
                    OP_SUB: begin
                        reg_we    = 1'b1;
                        reg_wdata = (reg_sel >= mem_rdata_reg) ? reg_sel - mem_rdata_reg : '0;
                    end
                    OP_SHR: begin
                        reg_we    = 1'b1;
                        reg_wdata = reg_sel >> 1;
                    end
                    OP_SHL: begin
                        reg_we    = 1'b1;
                        reg_wdata = reg_sel << 1;
                    end
                    OP_INC: begin
                        reg_we    = 1'b1;
                        reg_wdata = reg_sel + 1'b1;
                    end
                    OP_DEC: begin
                        reg_we    = 1'b1;
                        reg_wdata = (reg_sel != '0) ? reg_sel - 1'b1 : '0;
                    end
                    OP_ZERO: begin
                        reg_we    = 1'b1;
                        reg_wdata = '0;
                    end
                    OP_JUMP: next_pc17 = {1'b0, head_data.jump_target};
                    OP_JZERO: begin
                        if (reg_sel == '0) begin
                            next_pc17 = {1'b0, head_data.jump_target};
                        end
                    end
                    OP_JODD: begin
                        if (reg_sel[0]) begin
                            next_pc17 = {1'b0, head_data.jump_target};
                        end
                    end
                    OP_STORE, OP_HALT, OP_COMMENT: begin
                    end
                    default: begin
                    end
                endcase
                pc_next = next_pc17[PC_W-1:0];
                if (next_pc17 >= limit) begin
                    halt_next  = 1'b1;
                    res_status = STAT_PC_RANGE;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (complete) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            pc_reg       <= '0;
            cost_reg     <= '0;
            halt_reg     <= 1'b0;
            plen_reg     <= PLEN_RESET;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pc_reg       <= pc_next;
            cost_reg     <= cost_next;
            halt_reg     <= halt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                plen_reg <= cfg_wr_data;
            end
            if (reg_we) begin
                regs_reg[reg_widx] <= reg_wdata;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (complete) begin
            m_next_pc_reg   <= pc_next;
            m_put_valid_reg <= res_put;
            m_put_value_reg <= res_put ? reg_sel : '0;
            m_halted_reg    <= halt_next;
            m_status_reg    <= res_status;
        end
    end

    // data memory, single port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_next_pc    = m_next_pc_reg;
    assign m_put_valid  = m_put_valid_reg;
    assign m_put_value  = m_put_value_reg;
    assign m_halted     = m_halted_reg;
    assign m_status     = m_status_reg;
    assign m_total_cost = cost_reg;

    a_memrd_after_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MEMRD) |-> $past(state_reg == S_EXEC && mem_re))
        else $error("memory read wait without issued read");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    a_put_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_put_valid_reg) |-> (m_put_value_reg == '0))
        else $error("put value non-zero without put");

endmodule

// ----- rtl/core/register_machine_execute_core.sv -----
// ----------------------------------------------------------------------------
// register_machine_execute_core
// five-register machine: executes one instruction per request
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one instruction request (opcode, register, jump target, get
//   value), valid/ready. m_ channel: one result per request (next pc, put
//   output, halted, status, running cost), valid/ready.
//   cfg_wr_en/cfg_wr_data write the program length; write only while idle.
// flow and throughput
//   an accepted request waits in the queue, then executes into the result
//   register; load, add and sub first read the data memory at the address in
//   register 0 and wait in the read state. the execute stage takes one
//   instruction per cycle while results are taken, but not during that wait.
// reset
//   registers, pc, cost and halt flag clear at once; the data memory is then
//   swept to zero, one word a cycle, over all MEM_DEPTH words, during which
//   s_ready stays low. program length returns to 65536.
// stall
//   a held result does not block intake: up to two decoded requests queue
//   ahead of the execute stage, and s_ready drops once that queue is full.
// ----------------------------------------------------------------------------
module register_machine_execute_core #(
    parameter int MEM_DEPTH  = rme_pkg::MEM_DEPTH_DEF,
    parameter int PROG_DEPTH = rme_pkg::PROG_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [rme_pkg::PLEN_W-1:0]    cfg_wr_data,
    // instruction requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rme_pkg::OP_W-1:0]      s_opcode,
    input  logic [rme_pkg::REG_IDX_W-1:0] s_reg_index,
    input  logic [rme_pkg::PC_W-1:0]      s_jump_target,
    input  logic [rme_pkg::DATA_W-1:0]    s_get_value,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rme_pkg::PC_W-1:0]      m_next_pc,
    output logic                          m_put_valid,
    output logic [rme_pkg::DATA_W-1:0]    m_put_value,
    output logic                          m_halted,
    output logic [rme_pkg::STATUS_W-1:0]  m_status,
    output logic [rme_pkg::DATA_W-1:0]    m_total_cost
);
    import rme_pkg::*;

    // front to queue
    logic   push_valid;
    instr_t push_data;
    logic   queue_full;
    // queue to back
    logic   head_valid;
    instr_t head_data;
    logic   pop;
    // memory sweep in progress
    logic   clearing;

    // intake and classification
    rme_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_reg_index   (s_reg_index),
        .s_jump_target (s_jump_target),
        .s_get_value   (s_get_value),
        .queue_full    (queue_full),
        .clearing      (clearing),
        .push_valid    (push_valid),
        .push_data     (push_data)
    );

    // decoupling queue
    rme_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // execution, machine state and result register
    rme_back #(
        .MEM_DEPTH  (MEM_DEPTH),
        .PROG_DEPTH (PROG_DEPTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .clearing     (clearing),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_pc    (m_next_pc),
        .m_put_valid  (m_put_valid),
        .m_put_value  (m_put_value),
        .m_halted     (m_halted),
        .m_status     (m_status),
        .m_total_cost (m_total_cost)
    );

endmodule

// ----- dv/tb_register_machine_execute_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_register_machine_execute_core
// self-checking bench: a table of directed requests, then random instruction
// streams kept clear of any stop, run under several program lengths and
// handshake pressure patterns; one stopping case closes the run
// ----------------------------------------------------------------------------
module tb_register_machine_execute_core;

    import rme_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MEM_WORDS    = MEM_DEPTH_DEF;
    localparam int PROG_WORDS   = PROG_DEPTH_DEF;
    localparam int ADDR_W       = $clog2(MEM_WORDS);
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int DIR_ROWS     = 24;

    // one instruction request as driven on the s_ channel
    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [REG_IDX_W-1:0] reg_index;
        logic [PC_W-1:0]      jump_target;
        logic [DATA_W-1:0]    get_value;
    } req_t;

    // one result as seen on the m_ channel
    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              put_valid;
        logic [DATA_W-1:0] put_value;
        logic              halted;
        status_t           status;
        logic [DATA_W-1:0] total_cost;
    } res_t;

    // predicted result plus the register and memory write it implies
    typedef struct packed {
        res_t              res;
        logic              reg_we;
        logic [2:0]        reg_sel;
        logic [DATA_W-1:0] reg_val;
        logic              mem_we;
        logic [ADDR_W-1:0] mem_addr;
        logic [DATA_W-1:0] mem_val;
    } exec_t;

    // directed row: the result is typed in only where it is obvious
    typedef struct packed {
        req_t req;
        logic typed;
        res_t res;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [PLEN_W-1:0]    cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_opcode;
    logic [REG_IDX_W-1:0] s_reg_index;
    logic [PC_W-1:0]      s_jump_target;
    logic [DATA_W-1:0]    s_get_value;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PC_W-1:0]      m_next_pc;
    logic                 m_put_valid;
    logic [DATA_W-1:0]    m_put_value;
    logic                 m_halted;
    logic [STATUS_W-1:0]  m_status;
    logic [DATA_W-1:0]    m_total_cost;

    // machine state as the bench believes it to be
    logic [DATA_W-1:0] mach_regs [NUM_REGS];
    logic [DATA_W-1:0] mach_mem  [MEM_WORDS];
    logic [PC_W-1:0]   mach_pc;
    logic [DATA_W-1:0] mach_cost;
    logic              mach_stopped;
    logic [PLEN_W-1:0] prog_len;

    res_t        expected_results [$];
    row_t        dir_tab [DIR_ROWS];
    int unsigned mismatches    = 0;
    int unsigned req_idle_pct  = 0;
    int unsigned res_stall_pct = 0;

    register_machine_execute_core #(
        .MEM_DEPTH  (MEM_WORDS),
        .PROG_DEPTH (PROG_WORDS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_reg_index   (s_reg_index),
        .s_jump_target (s_jump_target),
        .s_get_value   (s_get_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_pc     (m_next_pc),
        .m_put_valid   (m_put_valid),
        .m_put_value   (m_put_value),
        .m_halted      (m_halted),
        .m_status      (m_status),
        .m_total_cost  (m_total_cost)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // result side back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= res_stall_pct);
    end

    function automatic req_t mk_req(input logic [OP_W-1:0] op, input logic [2:0] ri,
                                    input logic [PC_W-1:0] tgt, input logic [DATA_W-1:0] gv);
        req_t q;
        q.opcode      = op;
        q.reg_index   = ri;
        q.jump_target = tgt;
        q.get_value   = gv;
        return q;
    endfunction

    // plain successful result: running, status ok
    function automatic res_t mk_res(input logic [PC_W-1:0] pc, input logic pv_en,
                                    input logic [DATA_W-1:0] pv, input logic [DATA_W-1:0] cost);
        res_t r;
        r.next_pc    = pc;
        r.put_valid  = pv_en;
        r.put_value  = pv;
        r.halted     = 1'b0;
        r.status     = STAT_OK;
        r.total_cost = cost;
        return r;
    endfunction

    // executes one instruction against the believed state, without committing it
    function automatic exec_t step_machine(input req_t rq);
        exec_t             e;
        logic [2:0]        r;
        logic [DATA_W-1:0] rv;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] cost;
        logic [PLEN_W-1:0] lim;
        logic [PLEN_W-1:0] nxt;
        e                = '0;
        e.res.next_pc    = mach_pc;
        e.res.halted     = 1'b1;
        e.res.status     = STAT_OK;
        e.res.total_cost = mach_cost;
        // stopped machine: request ignored, state reported as is
        if (mach_stopped)
            return e;
        // register numbers above four fold onto the last register
        r    = (rq.reg_index > 3'(NUM_REGS - 1)) ? 3'(NUM_REGS - 1) : rq.reg_index;
        rv   = mach_regs[r];
        addr = mach_regs[0];
        word = (addr < 64'(MEM_WORDS)) ? mach_mem[addr[ADDR_W-1:0]] : '0;
        lim  = (prog_len < 17'(PROG_WORDS)) ? prog_len : 17'(PROG_WORDS);
        nxt  = {1'b0, mach_pc} + 17'd1;
        cost = mach_cost;
        e.reg_sel = r;
        if (rq.opcode inside {OP_LOAD, OP_STORE, OP_ADD, OP_SUB}) begin
            cost = cost + 64'(COST_MEM);
            // address outside the store: charged, nothing written, pc held
            if (addr >= 64'(MEM_WORDS)) begin
                e.res.total_cost = cost;
                e.res.status     = STAT_MEM_RANGE;
                return e;
            end
        end
        case (rq.opcode)
            OP_GET: begin
                e.reg_we  = 1'b1;
                e.reg_val = rq.get_value;
                cost      = cost + 64'(COST_IO);
            end
            OP_PUT: begin
                e.res.put_valid = 1'b1;
                e.res.put_value = rv;
                cost            = cost + 64'(COST_IO);
            end
            OP_LOAD: begin
                e.reg_we  = 1'b1;
                e.reg_val = word;
            end
            OP_STORE: begin
                e.mem_we   = 1'b1;
                e.mem_addr = addr[ADDR_W-1:0];
                e.mem_val  = rv;
            end
            OP_COPY: begin
                e.reg_we  = 1'b1;
                e.reg_sel = '0;
                e.reg_val = rv;
                cost      = cost + 64'(COST_ALU);
            end
            OP_ADD: begin
                e.reg_we  = 1'b1;
                e.reg_val = rv + word;
            end
            OP_SUB: begin
                e.reg_we  = 1'b1;
                e.reg_val = (rv >= word) ? rv - word : '0;
            end
            OP_SHR, OP_SHL, OP_INC, OP_DEC, OP_ZERO: begin
                e.reg_we = 1'b1;
                cost     = cost + 64'(COST_ALU);
                case (rq.opcode)
                    OP_SHR:  e.reg_val = rv >> 1;
                    OP_SHL:  e.reg_val = rv << 1;
                    OP_INC:  e.reg_val = rv + 64'd1;
                    OP_DEC:  e.reg_val = (rv != '0) ? rv - 64'd1 : '0;
                    default: e.reg_val = '0;
                endcase
            end
            OP_JUMP: begin
                nxt  = {1'b0, rq.jump_target};
                cost = cost + 64'(COST_ALU);
            end
            OP_JZERO: begin
                if (rv == '0)
                    nxt = {1'b0, rq.jump_target};
                cost = cost + 64'(COST_ALU);
            end
            OP_JODD: begin
                if (rv[0])
                    nxt = {1'b0, rq.jump_target};
                cost = cost + 64'(COST_ALU);
            end
            // halt: stop in place, free of charge
            OP_HALT: return e;
            // comment and the unused codes just move on
            default: ;
        endcase
        e.res.next_pc    = nxt[PC_W-1:0];
        e.res.total_cost = cost;
        e.res.halted     = (nxt >= lim);
        e.res.status     = (nxt >= lim) ? STAT_PC_RANGE : STAT_OK;
        return e;
    endfunction

    // random instruction with content weighted towards edge values
    function automatic req_t draw_instr();
        req_t              q;
        logic [PLEN_W-1:0] lim;
        lim      = (prog_len < 17'(PROG_WORDS)) ? prog_len : 17'(PROG_WORDS);
        q.opcode = 5'($urandom_range(0, 16));
        if ($urandom_range(0, 24) == 0)
            q.opcode = 5'($urandom_range(17, 31));
        if ($urandom_range(0, 7) == 0)
            q.reg_index = 3'($urandom_range(5, 7));
        else
            q.reg_index = 3'($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0 || lim == '0)
            q.jump_target = 16'($urandom);
        else
            q.jump_target = 16'($urandom_range(0, lim - 1));
        case ($urandom_range(0, 7))
            0:       q.get_value = '0;
            1:       q.get_value = '1;
            2:       q.get_value = 64'h8000_0000_0000_0000;
            3, 4:    q.get_value = 64'($urandom_range(0, MEM_WORDS - 1));
            default: q.get_value = {$urandom, $urandom};
        endcase
        // pull the memory pointer back into the store now and then
        if (mach_regs[0] >= 64'(MEM_WORDS) && $urandom_range(0, 1) == 0) begin
            q.opcode    = ($urandom_range(0, 1) == 0) ? OP_ZERO : OP_GET;
            q.reg_index = '0;
        end
        if (q.opcode == OP_GET && q.reg_index == '0 && $urandom_range(0, 3) != 0)
            q.get_value = 64'($urandom_range(0, MEM_WORDS - 1));
        return q;
    endfunction

    // random instruction that leaves the machine running
    function automatic req_t pick_instr();
        req_t  cand;
        exec_t e;
        for (int t = 0; t < 32; t++) begin
            cand = draw_instr();
            e    = step_machine(cand);
            if (!e.res.halted)
                return cand;
        end
        // jump to zero is legal whenever the program is not empty
        return mk_req(OP_JUMP, '0, '0, {$urandom, $urandom});
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // present one request, wait for it to be taken, then predict its result
    task automatic send_instr(input req_t rq, input logic typed, input res_t typed_res);
        exec_t e;
        @(negedge aclk);
        while ($urandom_range(0, 99) < req_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= rq.opcode;
        s_reg_index   <= rq.reg_index;
        s_jump_target <= rq.jump_target;
        s_get_value   <= rq.get_value;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        e = step_machine(rq);
        if (e.reg_we)
            mach_regs[e.reg_sel] = e.reg_val;
        if (e.mem_we)
            mach_mem[e.mem_addr] = e.mem_val;
        mach_pc      = e.res.next_pc;
        mach_cost    = e.res.total_cost;
        mach_stopped = e.res.halted;
        expected_results.insert(expected_results.size(), typed ? typed_res : e.res);
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // program length write, only ever issued with nothing in flight
    task automatic write_prog_len(input logic [PLEN_W-1:0] len);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        prog_len = len;
    endtask

    // result checker: every accepted result against the oldest prediction
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, next_pc %h cost %h",
                         $time, m_next_pc, m_total_cost);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("next_pc", 64'(want.next_pc), 64'(m_next_pc));
                check_field("put_valid", 64'(want.put_valid), 64'(m_put_valid));
                check_field("put_value", want.put_value, m_put_value);
                check_field("halted", 64'(want.halted), 64'(m_halted));
                check_field("status", 64'(want.status), 64'(m_status));
                check_field("total_cost", want.total_cost, m_total_cost);
            end
        end
    end

    // hard stop if the handshakes ever hang
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [PLEN_W-1:0] len;
        int unsigned       n_items;
        int unsigned       mode;
        int unsigned       scenario;
        logic [OP_W-1:0]   mem_op;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_opcode      = '0;
        s_reg_index   = '0;
        s_jump_target = '0;
        s_get_value   = '0;

        // believed state after reset
        foreach (mach_regs[i])
            mach_regs[i] = '0;
        foreach (mach_mem[i])
            mach_mem[i] = '0;
        mach_pc      = '0;
        mach_cost    = '0;
        mach_stopped = 1'b0;
        prog_len     = PLEN_RESET;

        // directed walk over every non-stopping opcode; the running cost and
        // pc are typed in for the rows straight after reset and at extremes
        dir_tab = '{
            '{mk_req(OP_PUT,     3'd0, 16'd0,   '0),    1'b1, mk_res(16'd1, 1'b1, '0, 64'd100)},
            '{mk_req(OP_GET,     3'd0, 16'd0,   64'd5), 1'b1, mk_res(16'd2, 1'b0, '0, 64'd200)},
            // memory reads back zero straight after the clearing sweep
            '{mk_req(OP_LOAD,    3'd1, 16'd0,   '0),    1'b1, mk_res(16'd3, 1'b0, '0, 64'd210)},
            '{mk_req(OP_GET,     3'd2, 16'd0,   '1),    1'b1, mk_res(16'd4, 1'b0, '0, 64'd310)},
            '{mk_req(OP_STORE,   3'd2, 16'd0,   '0),    1'b0, '0},
            // all ones plus one wraps to zero
            '{mk_req(OP_INC,     3'd2, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_LOAD,    3'd3, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_PUT,     3'd3, 16'd0,   '0),    1'b1, mk_res(16'd8, 1'b1, '1, 64'd431)},
            '{mk_req(OP_ADD,     3'd3, 16'd0,   '0),    1'b0, '0},
            // zero minus all ones saturates at zero
            '{mk_req(OP_SUB,     3'd1, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_SHL,     3'd3, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_SHR,     3'd3, 16'd0,   '0),    1'b0, '0},
            // decrement of zero stays at zero
            '{mk_req(OP_DEC,     3'd1, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_DEC,     3'd3, 16'd0,   '0),    1'b0, '0},
            // register seven lands on register four
            '{mk_req(OP_GET,     3'd7, 16'd0,   64'd1), 1'b0, '0},
            '{mk_req(OP_JODD,    3'd7, 16'd40,  '0),    1'b0, '0},
            '{mk_req(OP_JZERO,   3'd1, 16'd100, '0),    1'b0, '0},
            '{mk_req(OP_JZERO,   3'd4, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_JUMP,    3'd0, 16'hFFFF, '0),   1'b1, mk_res(16'hFFFF, 1'b0, '0, 64'd559)},
            '{mk_req(OP_JODD,    3'd4, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_COPY,    3'd1, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_ZERO,    3'd4, 16'd0,   '0),    1'b0, '0},
            '{mk_req(OP_COMMENT, 3'd0, 16'd0,   '0),    1'b0, '0},
            // unused opcode with every field bit set behaves as a comment
            '{mk_req(5'h1F,      3'd7, 16'hFFFF, '1),   1'b0, '0}
        };

        // synchronous reset, then the core sweeps its memory with s_ready low
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_instr(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

        // random streams, one program length per phase: beyond the program
        // store, short, one word, the full store, then a random length
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0:       len = '1;
                1:       len = 17'($urandom_range(2, 64));
                2:       len = 17'd1;
                3:       len = 17'(PROG_WORDS);
                default: len = 17'($urandom_range(1, PROG_WORDS));
            endcase
            write_prog_len(len);
            mode = (ph < 4) ? ph : $urandom_range(0, 3);
            case (mode)
                0:       begin req_idle_pct = 0;  res_stall_pct = 0;  end
                1:       begin req_idle_pct = 48; res_stall_pct = 0;  end
                2:       begin req_idle_pct = 0;  res_stall_pct = 48; end
                default: begin req_idle_pct = 9;  res_stall_pct = 9;  end
            endcase
            // the one-word program only admits jumps back to zero
            n_items = (ph == 2) ? 40 : 115;
            repeat (n_items)
                send_instr(pick_instr(), 1'b0, '0);
        end

        // every stopping case ends the machine for good, so the run closes
        // with one of them, chosen by the seed, then requests that must be
        // ignored by the stopped machine
        wait_drained();
        scenario = $urandom_range(0, 4);
        case (scenario)
            3:       len = 17'($urandom_range(1, 1000));
            4:       len = '0;
            default: len = 17'(PROG_WORDS);
        endcase
        write_prog_len(len);
        req_idle_pct  = 9;
        res_stall_pct = 9;
        case (scenario)
            0: begin
                // explicit halt
                send_instr(mk_req(OP_JUMP, '0, '0, '0), 1'b0, '0);
                send_instr(mk_req(OP_HALT, 3'($urandom), 16'($urandom), {$urandom, $urandom}),
                           1'b0, '0);
            end
            1: begin
                // memory pointer at or past the end of the store
                case ($urandom_range(0, 3))
                    0:       mem_op = OP_LOAD;
                    1:       mem_op = OP_STORE;
                    2:       mem_op = OP_ADD;
                    default: mem_op = OP_SUB;
                endcase
                send_instr(mk_req(OP_JUMP, '0, '0, '0), 1'b0, '0);
                send_instr(mk_req(OP_GET, '0, '0, ($urandom_range(0, 1) == 0) ?
                                  64'(MEM_WORDS) : {$urandom, $urandom} | 64'(MEM_WORDS)),
                           1'b0, '0);
                send_instr(mk_req(mem_op, 3'($urandom), '0, '0), 1'b0, '0);
            end
            2: begin
                // pc + 1 past the last word of the program store
                send_instr(mk_req(OP_JUMP, '0, 16'hFFFF, '0), 1'b0, '0);
                send_instr(mk_req(OP_INC, 3'($urandom), '0, '0), 1'b0, '0);
            end
            3: begin
                // running off the end of a short program, or jumping past it
                if ($urandom_range(0, 1) == 0) begin
                    send_instr(mk_req(OP_JUMP, '0, 16'(len - 1), '0), 1'b0, '0);
                    send_instr(mk_req(OP_COMMENT, '0, '0, '0), 1'b0, '0);
                end else begin
                    send_instr(mk_req(OP_JUMP, '0, 16'($urandom_range(len, PROG_WORDS - 1)),
                                      '0), 1'b0, '0);
                end
            end
            default: begin
                // empty program: any next pc is out of range
                send_instr(mk_req(OP_JUMP, '0, 16'($urandom), '0), 1'b0, '0);
            end
        endcase
        repeat (4)
            send_instr(draw_instr(), 1'b0, '0);

        wait_drained();
        res_stall_pct = 0;
        // room for any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rme_pkg.sv
rtl/core/rme_front.sv
rtl/core/rme_queue.sv
rtl/core/rme_back.sv
rtl/core/register_machine_execute_core.sv
dv/tb_register_machine_execute_core.sv
